// ===== hw/rtl/uv_sphere_mesh_generator_assert.svh =====
// Assertion macros used by the checker of the sphere mesh block.
// Each macro expands to one labeled concurrent assertion that is off while reset is low.
`ifndef UV_SPHERE_MESH_GENERATOR_ASSERT_SVH
`define UV_SPHERE_MESH_GENERATOR_ASSERT_SVH

// Same-cycle implication.
`define UVSMG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("uvsmg assertion failed");

// Next-cycle implication.
`define UVSMG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("uvsmg assertion failed");

`endif

// ===== hw/rtl/uvsmg_pkg.sv =====
`default_nettype none
package uvsmg_pkg;

  localparam int unsigned MAX_SLICES_DEF   = 256;
  localparam int unsigned SINE_ENTRIES_DEF = 1024;

  localparam int unsigned RING_W   = 8;
  localparam int unsigned SEG_W    = 9;
  localparam int unsigned SLICE_W  = 9;
  localparam int unsigned STEP_W   = 16;
  localparam int unsigned RAD_W    = 16;
  localparam int unsigned PHASE_W  = 16;
  localparam int unsigned SIN_W    = 16;
  localparam int unsigned MAG_W    = 15;
  localparam int unsigned POS_W    = 17;
  localparam int unsigned TEX_W    = 17;
  localparam int unsigned IDX_W    = 16;

  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 184;
  localparam int unsigned OUT_TUSER_W = 1;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  // Field positions inside out_tdata.
  localparam int unsigned TEX_U_LSB = 51;
  localparam int unsigned TEX_V_LSB = 68;
  localparam int unsigned TRI_LSB   = 85;

  localparam logic [SLICE_W-1:0] NUM_SLICES_RST = 9'd32;
  localparam logic [STEP_W-1:0]  TURN_STEP_RST  = 16'd2048;
  localparam logic [RAD_W-1:0]   RADIUS_RST     = 16'd256;

  localparam logic [PHASE_W-1:0] QUARTER_TURN = 16'h4000;
  localparam logic [TEX_W-1:0]   TEX_ONE      = 17'h10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_SLICES = 2'd0,
    REG_TURN_STEP  = 2'd1,
    REG_RADIUS     = 2'd2
  } cfg_reg_t;

  typedef logic signed [SIN_W-1:0] sin_t;

endpackage
`default_nettype wire

// ===== hw/rtl/uvsmg_sincos.sv =====
`default_nettype none
// Registered sine and cosine lookup of one 16-bit phase. The table holds one
// quarter wave (SINE_ENTRIES/4 + 1 magnitudes) and is built at elaboration;
// SINE_ENTRIES must be a power of two.
module uvsmg_sincos #(
  parameter int unsigned SINE_ENTRIES = uvsmg_pkg::SINE_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic [uvsmg_pkg::PHASE_W-1:0]  phase,
  output uvsmg_pkg::sin_t                sin_r,
  output uvsmg_pkg::sin_t                cos_r
);
  import uvsmg_pkg::*;

  localparam int unsigned ADDR_W = $clog2(SINE_ENTRIES);
  localparam int unsigned QTR    = SINE_ENTRIES / 4;
  localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1846;
  localparam logic [63:0] ONE_Q40     = 64'd1 << 40;
  localparam logic [63:0] ENTRIES64   = 64'(SINE_ENTRIES);
  localparam logic [63:0] X_QUO       = HALF_PI_Q60 / ENTRIES64;
  localparam logic [63:0] X_REM       = HALF_PI_Q60 % ENTRIES64;
  localparam logic [ADDR_W-1:0] HALF_IDX = ADDR_W'(SINE_ENTRIES / 2);
  localparam logic [ADDR_W-2:0] QTR_IDX  = (ADDR_W-1)'(QTR);

  typedef logic [MAG_W-1:0] qtab_t [0:QTR];

  // Q60 fixed-point product with the same truncation as the table generator.
  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ah, al, bh, bl, mid;
    ah  = a >> 32;
    al  = a & 64'h0000_0000_FFFF_FFFF;
    bh  = b >> 32;
    bl  = b & 64'h0000_0000_FFFF_FFFF;
    mid = ah * bl + al * bh + ((al * bl) >> 32);
    return ah * bh * 64'd16 + (mid >> 28);
  endfunction

  // Shift-and-subtract quotient; it is only evaluated while the table is built.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] dvs);
    logic [63:0] quo, rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= dvs) begin
        rem    = rem - dvs;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Taylor series of sin over the first quarter, rounded to 32767 full scale.
  function automatic qtab_t build_qtab();
    qtab_t       tab;
    logic [63:0] m, x, term, sum, q40, v, den;
    int          q, t;
    for (q = 0; q <= int'(QTR); q++) begin
      m    = 64'(4 * q);
      x    = X_QUO * m + ((X_REM * m) >> ADDR_W);
      term = x;
      sum  = x;
      for (t = 1; t < 40 && term != 64'd0; t++) begin
        den  = 64'((2 * t) * (2 * t + 1));
        term = udiv64(mul_q60(mul_q60(term, x), x), den);
        if (t[0]) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      q40 = (sum + (64'd1 << 19)) >> 20;
      if (q40 > ONE_Q40) begin
        q40 = ONE_Q40;
      end
      v      = (q40 * 64'd32767 + (ONE_Q40 >> 1)) >> 40;
      tab[q] = v[MAG_W-1:0];
    end
    return tab;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  // The upper address bit selects the negative half wave; the rest folds
  // onto the quarter table.
  function automatic sin_t rom_lookup(input logic [ADDR_W-1:0] idx);
    logic [ADDR_W-2:0] k, q;
    logic [ADDR_W-1:0] diff;
    logic [MAG_W-1:0]  mag;
    k    = idx[ADDR_W-2:0];
    diff = HALF_IDX - {1'b0, k};
    q    = (k > QTR_IDX) ? diff[ADDR_W-2:0] : k;
    mag  = QTAB[q];
    return idx[ADDR_W-1] ? -sin_t'({1'b0, mag}) : sin_t'({1'b0, mag});
  endfunction

  logic [PHASE_W-1:0] phase_cos;
  sin_t               sin_nxt, cos_nxt;

  always_comb begin
    phase_cos = phase + QUARTER_TURN;
    sin_nxt   = rom_lookup(phase[PHASE_W-1 -: ADDR_W]);
    cos_nxt   = rom_lookup(phase_cos[PHASE_W-1 -: ADDR_W]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_r <= sin_nxt;
      cos_r <= cos_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/uv_sphere_mesh_generator.sv =====
`default_nettype none
// UV sphere mesh generator: for each grid point (ring, segment) it returns the
// vertex position, texture coordinates and, where the point starts a quad, the
// six indices of that quad's two triangles. One point is taken every clock while
// the result channel is not stalled; the vertex path has four register stages
// (phase multiply, sine table, radius times ring sine, times segment sine and
// cosine). Back-pressure on the result channel stalls each full stage whose
// successor cannot load, and the input is taken whenever a stage ahead has room.
// Configuration writes are accepted at any time but may only be issued while
// no point is in flight; register index 3 is ignored.
module uv_sphere_mesh_generator #(
  parameter int unsigned MAX_SLICES   = uvsmg_pkg::MAX_SLICES_DEF,
  parameter int unsigned SINE_ENTRIES = uvsmg_pkg::SINE_ENTRIES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // ring [7:0], segment [16:8], zero fill above
  input  logic [uvsmg_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // pos_x [16:0], pos_y [33:17], pos_z [50:34], tex_u [67:51], tex_v [84:68],
  // tri_index_0..5 [100:85] [116:101] [132:117] [148:133] [164:149] [180:165]
  output logic [uvsmg_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // quad_valid [0]
  output logic [uvsmg_pkg::OUT_TUSER_W-1:0]   out_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [uvsmg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [uvsmg_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import uvsmg_pkg::*;

  localparam int unsigned MAX_CLAMP = (MAX_SLICES > 511) ? 511 : MAX_SLICES;
  localparam logic [SLICE_W-1:0] MAX_SL = SLICE_W'(MAX_CLAMP);
  localparam int unsigned PI_W = RING_W + STEP_W;
  localparam int unsigned PJ_W = SEG_W + STEP_W;
  localparam int unsigned A_W  = RING_W + SLICE_W + 1;
  localparam int unsigned RS_W = RAD_W + 2;

  typedef struct packed {
    logic [TEX_W-1:0] tex_u;
    logic [TEX_W-1:0] tex_v;
    logic             quad;
    logic [IDX_W-1:0] t0;
    logic [IDX_W-1:0] t1;
    logic [IDX_W-1:0] t2;
    logic [IDX_W-1:0] t5;
  } carry_t;

  // Configuration registers.
  logic [SLICE_W-1:0] num_slices_r;
  logic [STEP_W-1:0]  turn_step_r;
  logic [RAD_W-1:0]   radius_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_slices_r <= NUM_SLICES_RST;
      turn_step_r  <= TURN_STEP_RST;
      radius_r     <= RADIUS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_NUM_SLICES: num_slices_r <= cfg_data[SLICE_W-1:0];
        REG_TURN_STEP:  turn_step_r  <= cfg_data[STEP_W-1:0];
        REG_RADIUS:     radius_r     <= cfg_data[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Slice count as used for the quad test and the indices.
  logic [SLICE_W-1:0] slices;
  logic [SLICE_W-1:0] parallels;
  logic [SLICE_W:0]   row_w;

  assign slices    = (num_slices_r > MAX_SL) ? MAX_SL : num_slices_r;
  assign parallels = slices >> 1;
  assign row_w     = {1'b0, slices} + 1'b1;

  // Pipeline flow control: a stage loads when it is empty or its successor moves.
  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;

  assign en4       = !v4_r || out_tready;
  assign en3       = !v3_r || en4;
  assign en2       = !v2_r || en3;
  assign en1       = !v1_r || en2;
  assign in_tready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_tvalid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // Stage 1: phase products, base index and quad test.
  logic [RING_W-1:0] ring_in;
  logic [SEG_W-1:0]  seg_in;
  logic [PI_W-1:0]   pi_r, pi_nxt;
  logic [PJ_W-1:0]   pj_r, pj_nxt;
  logic [IDX_W-1:0]  a_r, a_nxt;
  logic              quad1_r, quad1_nxt;
  logic [A_W-1:0]    a_full;

  assign ring_in = in_tdata[RING_W-1:0];
  assign seg_in  = in_tdata[RING_W +: SEG_W];

  always_comb begin
    pi_nxt    = PI_W'(ring_in) * PI_W'(turn_step_r);
    pj_nxt    = PJ_W'(seg_in) * PJ_W'(turn_step_r);
    a_full    = A_W'(ring_in) * A_W'(row_w) + A_W'(seg_in);
    a_nxt     = a_full[IDX_W-1:0];
    quad1_nxt = ({1'b0, ring_in} < parallels) && (seg_in < slices);
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      pi_r    <= pi_nxt;
      pj_r    <= pj_nxt;
      a_r     <= a_nxt;
      quad1_r <= quad1_nxt;
    end
  end

  // Stage 2: sine table reads, texture coordinates, triangle indices.
  sin_t si, ci, sj, cj;

  uvsmg_sincos #(.SINE_ENTRIES(SINE_ENTRIES)) u_ring_trig (
    .clk   (clk),
    .en    (en2),
    .phase (pi_r[PHASE_W-1:0]),
    .sin_r (si),
    .cos_r (ci)
  );

  uvsmg_sincos #(.SINE_ENTRIES(SINE_ENTRIES)) u_seg_trig (
    .clk   (clk),
    .en    (en2),
    .phase (pj_r[PHASE_W-1:0]),
    .sin_r (sj),
    .cos_r (cj)
  );

  carry_t           c2_r, c2_nxt;
  logic [PJ_W-1:0]  prod_u, prod_v, tex_one_w;
  logic [IDX_W-1:0] b_idx;

  always_comb begin
    tex_one_w    = PJ_W'(TEX_ONE);
    prod_u       = pj_r;
    prod_v       = {pi_r, 1'b0};
    c2_nxt.tex_u = (prod_u < tex_one_w) ? TEX_W'(tex_one_w - prod_u) : '0;
    c2_nxt.tex_v = (prod_v < tex_one_w) ? TEX_W'(tex_one_w - prod_v) : '0;
    c2_nxt.quad  = quad1_r;
    b_idx        = a_r + IDX_W'(row_w);
    if (quad1_r) begin
      c2_nxt.t0 = a_r;
      c2_nxt.t1 = b_idx;
      c2_nxt.t2 = b_idx + 1'b1;
      c2_nxt.t5 = a_r + 1'b1;
    end else begin
      c2_nxt.t0 = '0;
      c2_nxt.t1 = '0;
      c2_nxt.t2 = '0;
      c2_nxt.t5 = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      c2_r <= c2_nxt;
    end
  end

  // Stage 3: radius times ring sine and cosine, floored to Q8.8.
  logic signed [RAD_W+SIN_W:0] prod_rs, prod_ry;
  logic signed [RS_W-1:0]      rs3_r, rs3_nxt;
  logic [POS_W-1:0]            y3_r, y3_nxt;
  sin_t                        sj3_r, cj3_r;
  carry_t                      c3_r;

  always_comb begin
    prod_rs = $signed({1'b0, radius_r}) * si;
    prod_ry = $signed({1'b0, radius_r}) * ci;
    rs3_nxt = prod_rs[RAD_W+SIN_W -: RS_W];
    y3_nxt  = prod_ry[POS_W+14:15];
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      rs3_r <= rs3_nxt;
      y3_r  <= y3_nxt;
      sj3_r <= sj;
      cj3_r <= cj;
      c3_r  <= c2_r;
    end
  end

  // Stage 4: ring radius times segment sine and cosine; output register.
  logic signed [RS_W+SIN_W-1:0] prod_x, prod_z;
  logic [POS_W-1:0]             x4_r, x4_nxt, y4_r, z4_r, z4_nxt;
  carry_t                       c4_r;

  always_comb begin
    prod_x = rs3_r * sj3_r;
    prod_z = rs3_r * cj3_r;
    x4_nxt = prod_x[POS_W+14:15];
    z4_nxt = prod_z[POS_W+14:15];
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      x4_r <= x4_nxt;
      y4_r <= y3_r;
      z4_r <= z4_nxt;
      c4_r <= c3_r;
    end
  end

  assign out_tvalid = v4_r;
  assign out_tuser  = c4_r.quad;
  assign out_tdata  = {3'b000, c4_r.t5, c4_r.t2, c4_r.t0, c4_r.t2, c4_r.t1, c4_r.t0,
                       c4_r.tex_v, c4_r.tex_u, z4_r, y4_r, x4_r};

endmodule
`default_nettype wire

// ===== hw/rtl/uvsmg_checker.sv =====
`default_nettype none
`include "uv_sphere_mesh_generator_assert.svh"
module uvsmg_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tready,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [uvsmg_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input logic [uvsmg_pkg::OUT_TUSER_W-1:0]   out_tuser
);
  import uvsmg_pkg::*;

  logic [IDX_W-1:0] t0, t1, t2, t3, t4, t5;
  logic [TEX_W-1:0] tex_u, tex_v;
  logic             out_stall, idx_zero, quad_shape, tex_in_range;

  assign t0    = out_tdata[TRI_LSB + 0*IDX_W +: IDX_W];
  assign t1    = out_tdata[TRI_LSB + 1*IDX_W +: IDX_W];
  assign t2    = out_tdata[TRI_LSB + 2*IDX_W +: IDX_W];
  assign t3    = out_tdata[TRI_LSB + 3*IDX_W +: IDX_W];
  assign t4    = out_tdata[TRI_LSB + 4*IDX_W +: IDX_W];
  assign t5    = out_tdata[TRI_LSB + 5*IDX_W +: IDX_W];
  assign tex_u = out_tdata[TEX_U_LSB +: TEX_W];
  assign tex_v = out_tdata[TEX_V_LSB +: TEX_W];

  assign out_stall    = out_tvalid && !out_tready;
  assign idx_zero     = ((t0 | t1 | t2 | t3 | t4 | t5) == '0);
  assign quad_shape   = (t3 == t0) && (t4 == t2) && (t2 == IDX_W'(t1 + 1'b1))
                        && (t5 == IDX_W'(t0 + 1'b1));
  assign tex_in_range = (tex_u <= TEX_ONE) && (tex_v <= TEX_ONE);

  // A stalled result holds.
  `UVSMG_ASSERT_NXT(a_out_hold, clk, rst_n, out_stall, out_tvalid && $stable({out_tuser, out_tdata}))

  // With an empty output register the input is always ready.
  `UVSMG_ASSERT_IMP(a_in_free, clk, rst_n, !out_tvalid, in_tready)

  // Without a quad all six indices are zero.
  `UVSMG_ASSERT_IMP(a_no_quad_zero, clk, rst_n, out_tvalid && !out_tuser[0], idx_zero)

  // The two triangles of a quad share their corners.
  `UVSMG_ASSERT_IMP(a_quad_shape, clk, rst_n, out_tvalid && out_tuser[0], quad_shape)

  // Texture coordinates never exceed one.
  `UVSMG_ASSERT_IMP(a_tex_range, clk, rst_n, out_tvalid, tex_in_range)

endmodule

bind uv_sphere_mesh_generator uvsmg_checker u_checker (.*);
`default_nettype wire

// ===== test/uv_sphere_mesh_generator_test.sv =====
`default_nettype none
module uv_sphere_mesh_generator_test;
  import uvsmg_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int SINE_N = SINE_ENTRIES_DEF;
  localparam int MAX_PRINTED = 100;
  localparam real HALF_PI = 1.5707963267948966;

  typedef struct packed {
    logic [5:0][IDX_W-1:0] tri_idx;
    logic                  quad;
    logic [TEX_W-1:0]      tv;
    logic [TEX_W-1:0]      tu;
    logic [POS_W-1:0]      pz;
    logic [POS_W-1:0]      py;
    logic [POS_W-1:0]      px;
  } vertex_t;

  class mesh_point_board;
    logic [SLICE_W-1:0] slices;
    logic [STEP_W-1:0]  step;
    logic [RAD_W-1:0]   rad;
    int                 failures;
    vertex_t            expected_vertices[$];
    int                 sine_q15[SINE_N];

    function new();
      int m;
      int v;
      bit neg;
      slices = NUM_SLICES_RST;
      step = TURN_STEP_RST;
      rad = RADIUS_RST;
      failures = 0;
      // Fold every table entry into the first quarter wave so that the table
      // is exactly symmetric, then round half away from zero.
      for (int k = 0; k < SINE_N; k++) begin
        m = 4 * k;
        neg = 1'b0;
        if (m >= 2 * SINE_N) begin
          m = m - 2 * SINE_N;
          neg = 1'b1;
        end
        if (m > SINE_N) m = 2 * SINE_N - m;
        v = $rtoi(32767.0 * $sin(HALF_PI * m / SINE_N) + 0.5);
        sine_q15[k] = neg ? -v : v;
      end
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_NUM_SLICES: slices = d[SLICE_W-1:0];
        REG_TURN_STEP:  step = d[STEP_W-1:0];
        REG_RADIUS:     rad = d[RAD_W-1:0];
        default: ;
      endcase
    endfunction

    function longint sine_at(longint phase);
      return sine_q15[((phase & 65535) * SINE_N) >> 16];
    endfunction

    function vertex_t grid_vertex(logic [RING_W-1:0] ring, logic [SEG_W-1:0] seg);
      vertex_t vx;
      longint stp, r, ph_i, ph_j, si, ci, sj, cj, rs, prod, a, b, slc, par;
      stp = longint'(step);
      r = longint'(rad);
      ph_i = (longint'(ring) * stp) & 65535;
      ph_j = (longint'(seg) * stp) & 65535;
      si = sine_at(ph_i);
      ci = sine_at(ph_i + QUARTER_TURN);
      sj = sine_at(ph_j);
      cj = sine_at(ph_j + QUARTER_TURN);
      // Arithmetic shifts on signed values floor toward minus infinity.
      rs = (r * si) >>> 15;
      vx.px = POS_W'((rs * sj) >>> 15);
      vx.py = POS_W'((r * ci) >>> 15);
      vx.pz = POS_W'((rs * cj) >>> 15);
      prod = longint'(seg) * stp;
      vx.tu = (prod < 65536) ? TEX_W'(65536 - prod) : '0;
      prod = 2 * longint'(ring) * stp;
      vx.tv = (prod < 65536) ? TEX_W'(65536 - prod) : '0;
      slc = longint'(slices);
      if (slc > MAX_SLICES_DEF) slc = MAX_SLICES_DEF;
      par = slc >> 1;
      vx.quad = 1'b0;
      vx.tri_idx = '0;
      if (longint'(ring) < par && longint'(seg) < slc) begin
        a = longint'(ring) * (slc + 1) + longint'(seg);
        b = a + slc + 1;
        vx.quad = 1'b1;
        vx.tri_idx[0] = IDX_W'(a);
        vx.tri_idx[1] = IDX_W'(b);
        vx.tri_idx[2] = IDX_W'(b + 1);
        vx.tri_idx[3] = IDX_W'(a);
        vx.tri_idx[4] = IDX_W'(b + 1);
        vx.tri_idx[5] = IDX_W'(a + 1);
      end
      return vx;
    endfunction

    function void note_point(logic [IN_TDATA_W-1:0] d);
      expected_vertices.push_back(grid_vertex(d[RING_W-1:0], d[RING_W +: SEG_W]));
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        if (failures < MAX_PRINTED)
          $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_vertex(logic [OUT_TDATA_W-1:0] d, logic [OUT_TUSER_W-1:0] u);
      vertex_t want;
      if (expected_vertices.size() == 0) begin
        $error("result transfer with no grid point outstanding");
        failures++;
        return;
      end
      want = expected_vertices.pop_front();
      compare_field("pos_x", $signed(want.px), $signed(d[0 +: POS_W]));
      compare_field("pos_y", $signed(want.py), $signed(d[POS_W +: POS_W]));
      compare_field("pos_z", $signed(want.pz), $signed(d[2*POS_W +: POS_W]));
      compare_field("tex_u", want.tu, d[TEX_U_LSB +: TEX_W]);
      compare_field("tex_v", want.tv, d[TEX_V_LSB +: TEX_W]);
      compare_field("quad_valid", want.quad, u[0]);
      for (int k = 0; k < 6; k++)
        compare_field($sformatf("tri_index_%0d", k), want.tri_idx[k],
                      d[TRI_LSB + IDX_W*k +: IDX_W]);
    endfunction

    function int pending();
      return expected_vertices.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  mesh_point_board board;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  uv_sphere_mesh_generator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Transfer monitor, receiver stalls and the no-progress watchdog.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (in_tvalid && in_tready) board.note_point(in_tdata);
    if (out_tvalid && out_tready) board.check_vertex(out_tdata, out_tuser);
    if (cfg_valid && cfg_ready) board.set_reg(cfg_reg_t'(cfg_index), cfg_data);
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_point(input logic [RING_W-1:0] ring, input logic [SEG_W-1:0] seg);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_TDATA_W'({seg, ring});
    do @(posedge clk); while (!(in_tvalid && in_tready));
  endtask

  // The extra edge lets the monitor record the final input transfer.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
  endtask

  task automatic program_sphere(input logic [15:0] sl, input logic [15:0] st,
                                input logic [15:0] rd);
    write_reg(REG_NUM_SLICES, sl);
    write_reg(REG_TURN_STEP, st);
    write_reg(REG_RADIUS, rd);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly points on the configured grid, the rest anywhere in the field range.
  task automatic random_points(input int n, input int slc);
    logic [RING_W-1:0] r;
    logic [SEG_W-1:0]  s;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 7) begin
        r = RING_W'($urandom_range(slc / 2));
        s = SEG_W'($urandom_range(slc));
      end else begin
        r = RING_W'($urandom);
        s = SEG_W'($urandom);
      end
      send_point(r, s);
    end
  endtask

  task automatic run_setting(input logic [15:0] sl, input logic [15:0] st,
                             input logic [15:0] rd, input int n);
    int slc;
    int send_pcts[4];
    int recv_pcts[4];
    send_pcts = '{0, 72, 0, 36};
    recv_pcts = '{0, 0, 72, 36};
    program_sphere(sl, st, rd);
    slc = int'(sl[SLICE_W-1:0]);
    if (slc > MAX_SLICES_DEF) slc = MAX_SLICES_DEF;
    // Last quad of the grid and the last grid point, which starts no quad.
    send_point(RING_W'(slc / 2 - 1), SEG_W'(slc - 1));
    send_point(RING_W'(slc / 2), SEG_W'(slc));
    for (int mode = 0; mode < 4; mode++) begin
      send_idle_pct = send_pcts[mode];
      recv_stall_pct = recv_pcts[mode];
      random_points(n / 4, slc);
    end
    drain();
  endtask

  initial begin
    int sl;
    board = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: poles, seams, grid edges and texture underflow.
    send_point(8'd0, 9'd0);
    send_point(8'd16, 9'd32);
    send_point(8'd15, 9'd31);
    send_point(8'd16, 9'd0);
    send_point(8'd0, 9'd32);
    send_point(8'd255, 9'd511);
    send_point(8'd255, 9'd0);
    send_point(8'd0, 9'd511);
    send_point(8'd8, 9'd8);
    send_point(8'd4, 9'd24);
    send_point(8'd1, 9'd17);
    send_point(8'd20, 9'd40);
    send_point(8'd12, 9'd5);
    drain();

    run_setting(16'd256, 16'd256, 16'hFFFF, 164);
    run_setting(16'd2, 16'd32768, 16'd0, 164);
    run_setting(16'hFE04, 16'd16384, 16'd1, 164);
    run_setting(16'd0, 16'd0, 16'h8000, 164);
    run_setting(16'd1, 16'hFFFF, 16'($urandom), 164);
    run_setting(16'd33, 16'd1986, 16'($urandom), 164);
    run_setting(16'hFFFF, 16'($urandom), 16'($urandom), 164);
    run_setting(16'd300, 16'd218, 16'($urandom), 164);
    repeat (2) begin
      sl = 2 * $urandom_range(1, 128);
      run_setting(16'(sl), 16'(65536 / sl), 16'($urandom), 164);
    end

    repeat (10) @(posedge clk);
    if (board.failures == 0 && board.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== uv_sphere_mesh_generator.f =====
+incdir+hw/rtl
hw/rtl/uvsmg_pkg.sv
hw/rtl/uvsmg_sincos.sv
hw/rtl/uv_sphere_mesh_generator.sv
hw/rtl/uvsmg_checker.sv
test/uv_sphere_mesh_generator_test.sv
